// ----- sv/dns_charstring_text_parser_macros.svh -----
// Assertion macros for the DNS character-string text parser.
// No dependencies; taken in by the top level with an include.
`ifndef DNS_CHARSTRING_TEXT_PARSER_MACROS_SVH
`define DNS_CHARSTRING_TEXT_PARSER_MACROS_SVH

// Implication at the same clock edge, ignored during reset.
`define DCSP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Implication into the following clock edge, ignored during reset.
`define DCSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/dcsp_pkg.sv -----
// Shared types and constants for the DNS character-string text parser.
// No dependencies; used by every module of the block.
package dcsp_pkg;

  // Default longest string in octets.
  localparam int MAX_LEN_DEF = 255;

  // Characters that steer the decoder.
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;

  // Largest octet value a decimal escape may spell.
  localparam logic [9:0] OCTET_MAX = 10'd255;

  // Status reported on the word that ends a string.
  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_MISSING   = 3'd1,
    ERR_PREMATURE = 3'd2,
    ERR_BADESC    = 3'd3,
    ERR_RANGE     = 3'd4,
    ERR_LONG      = 3'd5,
    ERR_UNPAIRED  = 3'd6
  } err_t;

  // Decoder phase, one-hot.
  typedef enum logic [5:0] {
    PH_START   = 6'b000001,
    PH_BODY    = 6'b000010,
    PH_ESC     = 6'b000100,
    PH_NUM1    = 6'b001000,
    PH_NUM2    = 6'b010000,
    PH_BADWAIT = 6'b100000
  } phase_t;

  // One result word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic       was_quoted;
    logic [2:0] error_code;
  } res_t;

endpackage

// ----- sv/dcsp_decode.sv -----
// Decoder state and the combinational step that turns one text word into at
// most one result word. Depends on dcsp_pkg.
module dcsp_decode #(
  parameter int MAX_LEN = dcsp_pkg::MAX_LEN_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      in_byte,
  input  logic            end_of_input,
  output logic            emit,
  output dcsp_pkg::res_t  res
);
  import dcsp_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 2);
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

  phase_t           phase, phase_next;
  logic             quoted_mode, quoted_mode_next;
  logic [6:0]       escape_value, escape_value_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;

  logic             is_digit;
  logic [3:0]       digit;
  logic [9:0]       acc;
  logic             qm_eff;
  logic [CNT_W-1:0] cnt_eff;
  logic             in_body;
  logic             do_put;
  logic [7:0]       put_val;
  logic             do_fin;
  err_t             fin_err;
  err_t             end_err;

  // Digit decode and the times-ten accumulate.
  assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign digit    = 4'(in_byte - CH_ZERO);
  assign acc      = ({3'b000, escape_value} << 3) + ({3'b000, escape_value} << 1)
                    + {6'd0, digit};

  // One decoding step.
  always_comb begin
    phase_next        = phase;
    quoted_mode_next  = quoted_mode;
    escape_value_next = escape_value;
    byte_count_next   = byte_count;
    qm_eff            = quoted_mode;
    cnt_eff           = byte_count;
    in_body           = 1'b0;
    do_put            = 1'b0;
    put_val           = in_byte;
    do_fin            = 1'b0;
    fin_err           = ERR_OK;
    end_err           = ERR_OK;

    case (phase)
      PH_BODY: begin
        in_body = 1'b1;
      end
      PH_ESC: begin
        if (end_of_input) begin
          do_fin  = 1'b1;
          fin_err = ERR_PREMATURE;
        end else if (is_digit) begin
          escape_value_next = {3'b000, digit};
          phase_next        = PH_NUM1;
        end else begin
          do_put = 1'b1;
        end
      end
      PH_NUM1: begin
        if (end_of_input) begin
          do_fin  = 1'b1;
          fin_err = ERR_PREMATURE;
        end else if (is_digit) begin
          escape_value_next = acc[6:0];
          phase_next        = PH_NUM2;
        end else begin
          phase_next = PH_BADWAIT;
        end
      end
      PH_NUM2: begin
        if (end_of_input) begin
          do_fin  = 1'b1;
          fin_err = ERR_PREMATURE;
        end else if (!is_digit) begin
          do_fin  = 1'b1;
          fin_err = ERR_BADESC;
        end else begin
          escape_value_next = '0;
          if (acc > OCTET_MAX) begin
            do_fin  = 1'b1;
            fin_err = ERR_RANGE;
          end else begin
            do_put  = 1'b1;
            put_val = acc[7:0];
          end
        end
      end
      PH_BADWAIT: begin
        do_fin  = 1'b1;
        fin_err = end_of_input ? ERR_PREMATURE : ERR_BADESC;
      end
      default: begin
        // Start of a string; unused codes land here too.
        if (end_of_input) begin
          do_fin  = 1'b1;
          fin_err = ERR_MISSING;
        end else begin
          phase_next        = PH_BODY;
          qm_eff            = 1'b0;
          cnt_eff           = '0;
          escape_value_next = '0;
          byte_count_next   = '0;
          if (in_byte == CH_QUOTE) begin
            quoted_mode_next = 1'b1;
          end else begin
            quoted_mode_next = 1'b0;
            in_body          = 1'b1;
          end
        end
      end
    endcase

    // Ordinary text inside the string.
    end_err = (cnt_eff > CNT_MAX) ? ERR_LONG : ERR_OK;
    if (in_body) begin
      if (end_of_input) begin
        do_fin  = 1'b1;
        fin_err = (end_err == ERR_OK && qm_eff) ? ERR_UNPAIRED : end_err;
      end else if (in_byte == CH_BACKSLASH) begin
        phase_next = PH_ESC;
      end else if (qm_eff && in_byte == CH_QUOTE) begin
        do_fin  = 1'b1;
        fin_err = end_err;
      end else if (!qm_eff && in_byte == CH_SPACE) begin
        do_fin  = 1'b1;
        fin_err = end_err;
      end else begin
        do_put = 1'b1;
      end
    end

    // Build the result word and settle the next state.
    emit            = do_put || do_fin;
    res.out_byte    = do_put ? put_val : 8'd0;
    res.byte_valid  = do_put;
    res.string_done = do_fin;
    res.was_quoted  = qm_eff;
    res.error_code  = do_fin ? fin_err : ERR_OK;
    if (do_put) begin
      phase_next      = PH_BODY;
      byte_count_next = (cnt_eff < CNT_SAT) ? cnt_eff + 1'b1 : cnt_eff;
    end
    if (do_fin) begin
      phase_next        = PH_START;
      quoted_mode_next  = 1'b0;
      escape_value_next = '0;
      byte_count_next   = '0;
    end
  end

  // State registers, advanced once per consumed word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      quoted_mode  <= 1'b0;
      escape_value <= '0;
      byte_count   <= '0;
    end else if (step) begin
      phase        <= phase_next;
      quoted_mode  <= quoted_mode_next;
      escape_value <= escape_value_next;
      byte_count   <= byte_count_next;
    end
  end

endmodule

// ----- sv/dcsp_out_reg.sv -----
// Output register for result words with valid/stall handshake.
// Depends on dcsp_pkg.
module dcsp_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  dcsp_pkg::res_t load_data,
  output logic           ready,
  output logic           out_valid,
  input  logic           out_stall,
  output dcsp_pkg::res_t out_data
);
  import dcsp_pkg::*;

  // Room for a new word when empty or when the held word leaves this cycle.
  assign ready = !out_valid || !out_stall;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (ready && load) begin
      out_data <= load_data;
    end
  end

endmodule

// ----- sv/dns_charstring_text_parser.sv -----
// DNS character-string text parser, presentation text to octets.
// Depends on dcsp_pkg, dcsp_decode, dcsp_out_reg and the assertion macro header.
//
// Usage:
//   The input channel (in_valid, in_stall, in_byte, end_of_input) carries one
//   text byte per word, or an end marker with end_of_input high. The output
//   channel (out_valid, out_stall, out_byte, byte_valid, string_done,
//   was_quoted, error_code) carries decoded octets, and one word with
//   string_done high that closes each string and reports its status.
//   A word is moved at a rising edge where valid is high and stall is low.
//   An accepted input word waits in the input register; its result passes
//   through the decoder step into the result register, which drives the output.
//   Throughput: one word per cycle through a single decoder step, unless a result waits for room.
//   Words that produce no result (an opening quote, escape characters) never
//   touch the output register.
//   When the receiver stalls, the result register holds its word and the
//   input register holds a word whose result finds no room; in_stall rises
//   only while a result is waiting for room.
//   A synchronous reset empties both registers and returns the decoder to
//   the start of a string.
module dns_charstring_text_parser #(
  parameter int MAX_LEN = dcsp_pkg::MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       string_done,
  output logic       was_quoted,
  output logic [2:0] error_code
);
  import dcsp_pkg::*;
  `include "dns_charstring_text_parser_macros.svh"

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eoi;
  logic       s1_adv;
  logic       dec_emit;
  res_t       dec_res;
  logic       out_ready;
  res_t       out_data;

  // The held word moves on when it has no result or the output has room.
  assign s1_adv   = s1_valid && (out_ready || !dec_emit);
  assign in_stall = s1_valid && !s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= in_byte;
      s1_eoi  <= end_of_input;
    end
  end

  // Decoder step.
  dcsp_decode #(
    .MAX_LEN (MAX_LEN)
  ) u_decode (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_adv),
    .in_byte      (s1_byte),
    .end_of_input (s1_eoi),
    .emit         (dec_emit),
    .res          (dec_res)
  );

  // Result register.
  dcsp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_adv && dec_emit),
    .load_data (dec_res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_byte    = out_data.out_byte;
  assign byte_valid  = out_data.byte_valid;
  assign string_done = out_data.string_done;
  assign was_quoted  = out_data.was_quoted;
  assign error_code  = out_data.error_code;

  // A result word carries either an octet or the end of a string, never both.
  `DCSP_ASSERT_NOW(a_one_kind, clk, rst, out_valid, byte_valid != string_done)
  // A status other than success only comes with the closing word.
  `DCSP_ASSERT_NOW(a_err_on_done, clk, rst, out_valid && !string_done, error_code == ERR_OK)
  // A held input word is not dropped while its result waits for room.
  `DCSP_ASSERT_NEXT(a_hold_input, clk, rst, s1_valid && !s1_adv, s1_valid)
  // A word without an octet carries zero in out_byte.
  `DCSP_ASSERT_NOW(a_octet_zero, clk, rst, out_valid && !byte_valid, out_byte == 8'd0)

endmodule

// ----- dv/dns_charstring_text_parser_checker.sv -----
// Checker for the DNS character-string text parser: watches both channels,
// predicts every result word and compares it field by field.
// Depends on dcsp_pkg for the result word layout, the phase and status codes.
module dns_charstring_text_parser_checker #(
  parameter int MAX_LEN = dcsp_pkg::MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       byte_valid,
  input  logic       string_done,
  input  logic       was_quoted,
  input  logic [2:0] error_code,
  output int         fail_count,
  output int         pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  import dcsp_pkg::*;

  // Decoder state as the checker sees it.
  phase_t     dec_phase   = PH_START;
  logic       dec_quoted  = 1'b0;
  logic [9:0] esc_acc     = '0;
  logic [8:0] octet_count = '0;

  // Result words that the accepted text has caused and that have not yet arrived.
  res_t decoded_due[$];
  int   mismatches = 0;
  res_t got_word;
  res_t want_word;

  // Prints one line for a mismatch and counts it; printing stops after a hundred.
  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("ERROR at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // A decoded octet leaves the block; the count saturates one past the limit.
  task automatic emit_octet(input logic [7:0] v);
    res_t w;
    w.out_byte    = v;
    w.byte_valid  = 1'b1;
    w.string_done = 1'b0;
    w.was_quoted  = dec_quoted;
    w.error_code  = ERR_OK;
    decoded_due = {decoded_due, w};
    if (octet_count < MAX_LEN + 1) octet_count = octet_count + 9'd1;
    dec_phase = PH_BODY;
  endtask

  // The word that ends a string carries its status, then all state clears.
  task automatic close_string(input err_t status);
    res_t w;
    w.out_byte    = 8'h00;
    w.byte_valid  = 1'b0;
    w.string_done = 1'b1;
    w.was_quoted  = dec_quoted;
    w.error_code  = status;
    decoded_due = {decoded_due, w};
    dec_phase   = PH_START;
    dec_quoted  = 1'b0;
    esc_acc     = '0;
    octet_count = '0;
  endtask

  // One accepted text word moves the decoder on by one step.
  task automatic decode_text_byte(input logic [7:0] b, input logic eoi);
    logic       digit;
    logic       in_body;
    logic [9:0] v;
    err_t       status;
    digit   = (b >= CH_ZERO) && (b <= CH_NINE);
    in_body = 1'b0;
    case (dec_phase)
      PH_BODY: in_body = 1'b1;
      PH_ESC: begin
        if (eoi) close_string(ERR_PREMATURE);
        else if (digit) begin
          esc_acc   = 10'(b - CH_ZERO);
          dec_phase = PH_NUM1;
        end else emit_octet(b);
      end
      PH_NUM1: begin
        if (eoi) close_string(ERR_PREMATURE);
        else if (digit) begin
          esc_acc   = 10'(esc_acc * 10 + (b - CH_ZERO));
          dec_phase = PH_NUM2;
        end else dec_phase = PH_BADWAIT;
      end
      PH_NUM2: begin
        if (eoi) close_string(ERR_PREMATURE);
        else if (!digit) close_string(ERR_BADESC);
        else begin
          v       = 10'(esc_acc * 10 + (b - CH_ZERO));
          esc_acc = '0;
          if (v > OCTET_MAX) close_string(ERR_RANGE);
          else emit_octet(v[7:0]);
        end
      end
      PH_BADWAIT: begin
        if (eoi) close_string(ERR_PREMATURE);
        else close_string(ERR_BADESC);
      end
      default: begin
        // Start of a string: an opening quote selects quoted mode.
        if (eoi) close_string(ERR_MISSING);
        else begin
          dec_phase   = PH_BODY;
          dec_quoted  = 1'b0;
          octet_count = '0;
          esc_acc     = '0;
          if (b == CH_QUOTE) dec_quoted = 1'b1;
          else in_body = 1'b1;
        end
      end
    endcase

    // Body of the string; too long wins over an unpaired quote.
    if (in_body) begin
      status = (octet_count > MAX_LEN) ? ERR_LONG : ERR_OK;
      if (eoi) close_string((status == ERR_OK && dec_quoted) ? ERR_UNPAIRED : status);
      else if (b == CH_BACKSLASH) dec_phase = PH_ESC;
      else if (dec_quoted && b == CH_QUOTE) close_string(status);
      else if (!dec_quoted && b == CH_SPACE) close_string(status);
      else emit_octet(b);
    end
  endtask

  // Predict on every accepted input word, compare on every accepted result word.
  always @(posedge clk) begin
    if (rst) begin
      dec_phase   = PH_START;
      dec_quoted  = 1'b0;
      esc_acc     = '0;
      octet_count = '0;
      decoded_due.delete();
    end else begin
      if (in_valid && !in_stall) decode_text_byte(in_byte, end_of_input);
      if (out_valid && !out_stall) begin
        got_word = {out_byte, byte_valid, string_done, was_quoted, error_code};
        if (decoded_due.size() == 0) begin
          report_mismatch($sformatf("result word %0h with nothing expected", got_word));
        end else begin
          want_word = decoded_due.pop_front();
          if (got_word.out_byte !== want_word.out_byte)
            report_mismatch($sformatf("out_byte %0h, expected %0h",
                                      got_word.out_byte, want_word.out_byte));
          if (got_word.byte_valid !== want_word.byte_valid)
            report_mismatch($sformatf("byte_valid %0b, expected %0b",
                                      got_word.byte_valid, want_word.byte_valid));
          if (got_word.string_done !== want_word.string_done)
            report_mismatch($sformatf("string_done %0b, expected %0b",
                                      got_word.string_done, want_word.string_done));
          if (got_word.was_quoted !== want_word.was_quoted)
            report_mismatch($sformatf("was_quoted %0b, expected %0b",
                                      got_word.was_quoted, want_word.was_quoted));
          if (got_word.error_code !== want_word.error_code)
            report_mismatch($sformatf("error_code %0d, expected %0d",
                                      got_word.error_code, want_word.error_code));
        end
      end
    end
    pending_words <= decoded_due.size();
    fail_count    <= mismatches;
  end

endmodule

// ----- dv/dns_charstring_text_parser_tb.sv -----
// Testbench top for the DNS character-string text parser: clock, reset,
// text stimulus, receiver stalls, watchdog and the final verdict.
// Depends on dcsp_pkg, the block itself and dns_charstring_text_parser_checker.
module dns_charstring_text_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dcsp_pkg::*;

  localparam int ITEMS          = 1850;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 10;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte      = 8'h00;
  logic       end_of_input = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;
  logic       was_quoted;
  logic [2:0] error_code;
  int         fail_count;
  int         pending_words;
  int         items_sent   = 0;

  dns_charstring_text_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_byte(in_byte), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .byte_valid(byte_valid), .string_done(string_done),
    .was_quoted(was_quoted), .error_code(error_code)
  );

  dns_charstring_text_parser_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_byte(in_byte), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .byte_valid(byte_valid), .string_done(string_done),
    .was_quoted(was_quoted), .error_code(error_code),
    .fail_count(fail_count), .pending_words(pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offers one word after a random gap and holds it until it is taken.
  // The sender never idles in a stretch in the middle of the run.
  task automatic send_word(input logic [7:0] b, input logic eoi);
    int gap_pct;
    gap_pct = (items_sent >= 1000 && items_sent < 1400) ? 0 : 7;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  // An ordinary text byte: never a backslash, a quote, or a space outside quotes.
  function automatic logic [7:0] pick_plain(input logic quoted);
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == CH_BACKSLASH || b == CH_QUOTE || (!quoted && b == CH_SPACE));
    return b;
  endfunction

  // Receiver: random stalls, one long hold-off that backs the block up,
  // and a stretch without any stall.
  initial begin : receiver
    int cyc;
    cyc = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 700 && cyc < 1100) out_stall <= 1'b1;
      else if (cyc >= 1500 && cyc < 2000) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(99) < 7);
    end
  end

  // Ends the run when no word has moved on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("ERROR: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int         strings_made;
    int         kind;
    int         len;
    int         v;
    logic       q;
    logic [7:0] b;
    strings_made = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: end with no field, empty unquoted string, extreme octets,
    // escaped quote, unpaired quote, premature ends, decimal escapes at and
    // over the octet limit, and a bad escape.
    send_word(8'h00, 1'b1);
    send_text(" ");
    send_text("\"");
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_text("\\\"");
    send_word(8'hFF, 1'b1);
    send_text("\\");
    send_word(8'h00, 1'b1);
    send_text("\\255 ");
    send_text("\\256");
    send_text("\\1xy");
    send_text("\\1x");
    send_word(8'h00, 1'b1);

    // Random strings, mostly well formed, with noise and broken escapes.
    while (items_sent < ITEMS) begin
      strings_made++;
      kind = $urandom_range(99);
      if (strings_made % 30 == 0 && strings_made <= 90) begin
        // Strings at and beyond the length limit.
        q   = (strings_made != 60);
        len = (strings_made == 60) ? MAX_LEN_DEF : MAX_LEN_DEF + 1 + $urandom_range(3);
        if (q) send_word(CH_QUOTE, 1'b0);
        repeat (len) send_word(pick_plain(q), 1'b0);
        if (strings_made == 30) send_word(8'($urandom), 1'b1);
        else send_word(q ? CH_QUOTE : CH_SPACE, 1'b0);
      end else if (kind < 70) begin
        q = 1'($urandom_range(1));
        if (q) send_word(CH_QUOTE, 1'b0);
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
        repeat (len) begin
          case ($urandom_range(9))
            0: begin
              do b = 8'($urandom);
              while (b >= CH_ZERO && b <= CH_NINE);
              send_word(CH_BACKSLASH, 1'b0);
              send_word(b, 1'b0);
            end
            1: begin
              v = $urandom_range(255);
              send_word(CH_BACKSLASH, 1'b0);
              send_word(CH_ZERO + 8'(v / 100), 1'b0);
              send_word(CH_ZERO + 8'((v / 10) % 10), 1'b0);
              send_word(CH_ZERO + 8'(v % 10), 1'b0);
            end
            default: send_word(pick_plain(q), 1'b0);
          endcase
        end
        if ($urandom_range(4) == 0) send_word(8'($urandom), 1'b1);
        else send_word(q ? CH_QUOTE : CH_SPACE, 1'b0);
      end else if (kind < 85) begin
        // Noise rich in the steering characters, closed by an end marker.
        repeat ($urandom_range(8, 1)) begin
          case ($urandom_range(5))
            0: b = CH_QUOTE;
            1: b = CH_BACKSLASH;
            2: b = CH_SPACE;
            3: b = CH_ZERO + 8'($urandom_range(9));
            default: b = 8'($urandom);
          endcase
          send_word(b, 1'($urandom_range(7) == 0));
        end
        send_word(8'($urandom), 1'b1);
      end else begin
        // Broken escapes: short or mixed digit runs, then an end marker.
        q = 1'($urandom_range(1));
        if (q) send_word(CH_QUOTE, 1'b0);
        repeat ($urandom_range(3)) send_word(pick_plain(q), 1'b0);
        send_word(CH_BACKSLASH, 1'b0);
        repeat ($urandom_range(3)) begin
          if ($urandom_range(1)) send_word(CH_ZERO + 8'($urandom_range(9)), 1'b0);
          else send_word(8'($urandom), 1'b0);
        end
        send_word(8'($urandom), 1'($urandom_range(1)));
        send_word(8'($urandom), 1'b1);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    // Let every expected word arrive, then allow for the pipeline to settle.
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/dcsp_pkg.sv
sv/dcsp_decode.sv
sv/dcsp_out_reg.sv
sv/dns_charstring_text_parser.sv
dv/dns_charstring_text_parser_checker.sv
dv/dns_charstring_text_parser_tb.sv
